FILE: design/sm83_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the SM83 register instruction executor.
// No dependencies; used by sm83_exec and the top level.
package sm83_pkg;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PREFIX  = 2'd1,
    ST_UNIMPL  = 2'd2,
    ST_ILLEGAL = 2'd3
  } status_t;

  typedef enum logic {
    ACT_EXEC    = 1'b0,
    ACT_PRELOAD = 1'b1
  } action_t;

  // Operand codes as they appear in opcode bits and in the preload selector
  localparam logic [2:0] OPND_B  = 3'd0;
  localparam logic [2:0] OPND_C  = 3'd1;
  localparam logic [2:0] OPND_D  = 3'd2;
  localparam logic [2:0] OPND_E  = 3'd3;
  localparam logic [2:0] OPND_H  = 3'd4;
  localparam logic [2:0] OPND_L  = 3'd5;
  localparam logic [2:0] OPND_HL = 3'd6;
  localparam logic [2:0] SEL_FLAGS = 3'd6;

  localparam logic [7:0] OP_NOP    = 8'h00;
  localparam logic [7:0] OP_HALT   = 8'h76;
  localparam logic [7:0] OP_LD_HLA = 8'h77;
  localparam logic [7:0] OP_RET    = 8'hC9;
  localparam logic [7:0] OP_PREFIX = 8'hCB;
  localparam logic [7:0] INC_MASK  = 8'hC7;
  localparam logic [7:0] INC_MATCH = 8'h04;

  // Opcode quadrants (bits 7:6)
  localparam logic [1:0] QUAD_LD  = 2'd1;
  localparam logic [1:0] QUAD_ALU = 2'd2;

  // Arithmetic groups (bits 5:3 of the ALU quadrant)
  localparam logic [2:0] GRP_ADD = 3'd0;
  localparam logic [2:0] GRP_ADC = 3'd1;
  localparam logic [2:0] GRP_SUB = 3'd2;
  localparam logic [2:0] GRP_SBC = 3'd3;
  localparam logic [2:0] GRP_AND = 3'd4;
  localparam logic [2:0] GRP_XOR = 3'd5;
  localparam logic [2:0] GRP_OR  = 3'd6;
  localparam logic [2:0] GRP_CP  = 3'd7;

  // Prefixed kinds (bits 7:6) and the SWAP slot in the rotate/shift kind
  localparam logic [1:0] KIND_ROT = 2'd0;
  localparam logic [1:0] KIND_BIT = 2'd1;
  localparam logic [1:0] KIND_RES = 2'd2;
  localparam logic [1:0] KIND_SET = 2'd3;
  localparam logic [2:0] ROT_SWAP = 3'd6;

  localparam logic [15:0] PC_RESET = 16'h0100;

  typedef struct packed {
    action_t    action;
    logic [7:0] instr_byte;
    logic [2:0] reg_select;
    logic [7:0] load_value;
  } item_t;

  // Flags: bit 3 Z, bit 2 N, bit 1 H, bit 0 C
  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [3:0]  flags;
    logic [15:0] pc;
    logic        prefix;
  } cpu_state_t;

  typedef struct packed {
    status_t    status;
    cpu_state_t regs;
  } result_t;

  function automatic logic [7:0] read_reg(cpu_state_t s, logic [2:0] code);
    logic [7:0] v;
    case (code)
      OPND_B:  v = s.b;
      OPND_C:  v = s.c;
      OPND_D:  v = s.d;
      OPND_E:  v = s.e;
      OPND_H:  v = s.h;
      OPND_L:  v = s.l;
      default: v = s.a;
    endcase
    return v;
  endfunction

  function automatic cpu_state_t write_reg(cpu_state_t s, logic [2:0] code,
                                           logic [7:0] v);
    cpu_state_t r;
    r = s;
    case (code)
      OPND_B:  r.b = v;
      OPND_C:  r.c = v;
      OPND_D:  r.d = v;
      OPND_E:  r.e = v;
      OPND_H:  r.h = v;
      OPND_L:  r.l = v;
      default: r.a = v;
    endcase
    return r;
  endfunction

endpackage

FILE: design/sm83_exec.sv
`timescale 1ns / 1ps
// Single-pass execute logic: decodes one word and computes the next register
// file, flags, program counter and status. Depends on sm83_pkg.
module sm83_exec (
  input  sm83_pkg::item_t      item,
  input  sm83_pkg::cpu_state_t cur,
  output sm83_pkg::cpu_state_t nxt,
  output sm83_pkg::status_t    status
);

  logic [7:0] op;
  logic [2:0] src;
  logic [2:0] dst;
  logic [1:0] quad;
  logic [7:0] a;
  logic [7:0] s;
  logic [7:0] dv;
  logic [8:0] sum;
  logic [4:0] hsum;
  logic [7:0] diff;
  logic [7:0] res;
  logic [7:0] mask;

  assign op   = item.instr_byte;
  assign src  = op[2:0];
  assign dst  = op[5:3];
  assign quad = op[7:6];
  assign a    = cur.a;
  assign s    = sm83_pkg::read_reg(cur, src);
  assign dv   = sm83_pkg::read_reg(cur, dst);
  assign sum  = {1'b0, a} + {1'b0, s};
  assign hsum = {1'b0, a[3:0]} + {1'b0, s[3:0]};
  assign diff = a - s;
  assign mask = 8'd1 << dst;

  always_comb begin
    nxt    = cur;
    status = sm83_pkg::ST_DONE;
    res    = 8'd0;
    if (item.action == sm83_pkg::ACT_PRELOAD) begin
      if (item.reg_select == sm83_pkg::SEL_FLAGS) begin
        nxt.flags = item.load_value[7:4];
      end else begin
        nxt = sm83_pkg::write_reg(cur, item.reg_select, item.load_value);
      end
    end else begin
      nxt.pc = cur.pc + 16'd1;
      if (cur.prefix) begin
        nxt.prefix = 1'b0;
        if ((quad == sm83_pkg::KIND_ROT && dst != sm83_pkg::ROT_SWAP) ||
            src == sm83_pkg::OPND_HL) begin
          status = sm83_pkg::ST_UNIMPL;
        end else begin
          case (quad)
            sm83_pkg::KIND_ROT: begin
              res = {s[3:0], s[7:4]};
              nxt = sm83_pkg::write_reg(nxt, src, res);
              nxt.flags = {res == 8'd0, 3'b000};
            end
            sm83_pkg::KIND_BIT: begin
              nxt.flags = {~|(s & mask), 1'b0, 1'b1, cur.flags[0]};
            end
            sm83_pkg::KIND_RES: begin
              nxt = sm83_pkg::write_reg(nxt, src, s & ~mask);
            end
            default: begin
              nxt = sm83_pkg::write_reg(nxt, src, s | mask);
            end
          endcase
        end
      end else if (op == sm83_pkg::OP_PREFIX) begin
        nxt.prefix = 1'b1;
        status     = sm83_pkg::ST_PREFIX;
      end else if (op == sm83_pkg::OP_NOP) begin
        status = sm83_pkg::ST_DONE;
      end else if (op == sm83_pkg::OP_HALT || op == sm83_pkg::OP_LD_HLA ||
                   op == sm83_pkg::OP_RET) begin
        status = sm83_pkg::ST_UNIMPL;
      end else if ((op & sm83_pkg::INC_MASK) == sm83_pkg::INC_MATCH) begin
        if (dst == sm83_pkg::OPND_HL) begin
          status = sm83_pkg::ST_ILLEGAL;
        end else begin
          res = dv + 8'd1;
          nxt = sm83_pkg::write_reg(nxt, dst, res);
          nxt.flags = {res == 8'd0, 1'b0, &dv[3:0], cur.flags[0]};
        end
      end else if (quad == sm83_pkg::QUAD_LD) begin
        if (dst == sm83_pkg::OPND_HL) begin
          status = sm83_pkg::ST_ILLEGAL;
        end else if (src == sm83_pkg::OPND_HL) begin
          status = sm83_pkg::ST_UNIMPL;
        end else begin
          nxt = sm83_pkg::write_reg(nxt, dst, s);
        end
      end else if (quad != sm83_pkg::QUAD_ALU ||
                   dst == sm83_pkg::GRP_ADC || dst == sm83_pkg::GRP_SBC) begin
        status = sm83_pkg::ST_ILLEGAL;
      end else if (src == sm83_pkg::OPND_HL) begin
        status = sm83_pkg::ST_UNIMPL;
      end else begin
        case (dst)
          sm83_pkg::GRP_ADD: begin
            res       = sum[7:0];
            nxt.a     = res;
            nxt.flags = {res == 8'd0, 1'b0, hsum[4], sum[8]};
          end
          sm83_pkg::GRP_SUB, sm83_pkg::GRP_CP: begin
            res = diff;
            if (dst == sm83_pkg::GRP_SUB) begin
              nxt.a = res;
            end
            nxt.flags = {res == 8'd0, 1'b1, a[3:0] < s[3:0], a < s};
          end
          sm83_pkg::GRP_AND: begin
            res       = a & s;
            nxt.a     = res;
            nxt.flags = {res == 8'd0, 1'b0, 1'b1, 1'b0};
          end
          sm83_pkg::GRP_XOR: begin
            res       = a ^ s;
            nxt.a     = res;
            nxt.flags = {res == 8'd0, 3'b000};
          end
          default: begin
            res       = a | s;
            nxt.a     = res;
            nxt.flags = {res == 8'd0, 3'b000};
          end
        endcase
      end
    end
  end

endmodule

FILE: design/sm83_register_instruction_executor.sv
`timescale 1ns / 1ps
// Top level of the SM83 register instruction executor: input register,
// architectural state, result register. Depends on sm83_pkg and sm83_exec.
//
// Each input word either executes one opcode byte or preloads a register, and
// yields exactly one result word carrying the status and the whole register
// file (A..L, flags, program counter) as they stand after that word. One word
// is accepted every clock cycle while the result side does not stall. The rate
// is set by the single execute stage, which reads and writes the register file
// in the same cycle, so each word sees the effect of the one before it with no
// bubble. Back-pressure on the result side holds the input register, and the
// input side keeps taking words while it has room.
module sm83_register_instruction_executor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] instr_byte, [10:8] reg_select, [18:11] load_value, [23:19] zero
  input  logic [23:0] s_axis_tdata,
  // [0] action
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_a, [15:8] out_b, [23:16] out_c, [31:24] out_d, [39:32] out_e,
  // [47:40] out_h, [55:48] out_l, [59:56] out_flags, [75:60] out_pc,
  // [79:76] zero
  output logic [79:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  logic                 in_valid;
  sm83_pkg::item_t      in_item;
  sm83_pkg::cpu_state_t cpu;
  sm83_pkg::cpu_state_t cpu_next;
  sm83_pkg::status_t    exec_status;
  logic                 out_valid;
  sm83_pkg::result_t    out_res;
  logic                 out_room;
  logic                 advance;

  assign out_room      = ~out_valid | m_axis_tready;
  assign advance       = in_valid & out_room;
  assign s_axis_tready = ~in_valid | advance;

  sm83_exec u_exec (
    .item   (in_item),
    .cur    (cpu),
    .nxt    (cpu_next),
    .status (exec_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.action     <= sm83_pkg::action_t'(s_axis_tuser);
      in_item.instr_byte <= s_axis_tdata[7:0];
      in_item.reg_select <= s_axis_tdata[10:8];
      in_item.load_value <= s_axis_tdata[18:11];
    end
  end

  // Commit state only when the word moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      // registers A..L and flags clear, program counter at its start address
      cpu <= {56'd0, 4'd0, sm83_pkg::PC_RESET, 1'b0};
    end else if (advance) begin
      cpu <= cpu_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_room) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res.status <= exec_status;
      out_res.regs   <= cpu_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {4'b0000, out_res.regs.pc, out_res.regs.flags,
                          out_res.regs.l, out_res.regs.h, out_res.regs.e,
                          out_res.regs.d, out_res.regs.c, out_res.regs.b,
                          out_res.regs.a};

endmodule
